// ----- rtl/core/bse_pkg.sv -----
`default_nettype none

package bse_pkg;

    localparam int DEF_SIDE    = 6;
    localparam int DEF_MAX_LEN = 64;

    localparam int SYM_W  = 8;
    localparam int CELL_W = 6;
    localparam int KIND_W = 2;

    // item kinds carried on tuser
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MSG  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIN  = 2'd2;

    typedef struct packed {
        logic cap;        // capture the message symbol
        logic sq_wr;      // write one square cell from the input item
        logic scan_clr;   // restart the square scan
        logic scan_inc;   // advance the square scan
        logic sel_pair;   // read the square at the pair index
        logic sq_hold;    // hold the square read data
        logic store;      // append row and column of the scan position
        logic seq_clr;    // restart the coordinate walk
        logic coord_inc;  // advance the coordinate walk
        logic latch_r;    // hold the row half of a pair
        logic emit;       // load the output register
        logic len_clr;    // empty the message
    } t_cmd;

    typedef struct packed {
        logic match;
        logic scan_last;
        logic full;
        logic empty;
        logic out_free;
        logic seq_done;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/core/bse_ctrl.sv -----
`default_nettype none

module bse_ctrl
    import bse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tvalid,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire t_sts              i_sts,
    output logic                   o_tready,
    output t_cmd                   o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LREAD = 3'd1;
    localparam logic [2:0] ST_LCMP  = 3'd2;
    localparam logic [2:0] ST_E0    = 3'd3;
    localparam logic [2:0] ST_E1    = 3'd4;
    localparam logic [2:0] ST_E2    = 3'd5;
    localparam logic [2:0] ST_E3    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_tready = (r_state == ST_IDLE);
    assign accept   = i_tvalid && o_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_LOAD: begin
                            o_cmd.sq_wr = 1'b1;
                        end
                        KIND_MSG: begin
                            o_cmd.cap      = 1'b1;
                            o_cmd.scan_clr = 1'b1;
                            if (!i_sts.full) begin
                                n_state = ST_LREAD;
                            end
                        end
                        KIND_FIN: begin
                            o_cmd.seq_clr = 1'b1;
                            if (!i_sts.empty) begin
                                n_state = ST_E0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LREAD: begin
                n_state = ST_LCMP;
            end
            ST_LCMP: begin
                if (i_sts.match) begin
                    o_cmd.store = 1'b1;
                    n_state     = ST_IDLE;
                end else if (i_sts.scan_last) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = ST_LREAD;
                end
            end
            ST_E0: begin
                o_cmd.coord_inc = 1'b1;
                n_state         = ST_E1;
            end
            ST_E1: begin
                o_cmd.latch_r   = 1'b1;
                o_cmd.coord_inc = 1'b1;
                n_state         = ST_E2;
            end
            ST_E2: begin
                o_cmd.sel_pair = 1'b1;
                n_state        = ST_E3;
            end
            ST_E3: begin
                // keep the pair's symbol while the output register is busy
                o_cmd.sq_hold = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.seq_done) begin
                        o_cmd.len_clr = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        n_state = ST_E0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bse_dp.sv -----
`default_nettype none

module bse_dp
    import bse_pkg::*;
#(
    parameter int SIDE    = DEF_SIDE,
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [CELL_W-1:0] i_cell,
    input  wire logic [SYM_W-1:0]  i_symbol,
    input  wire logic              i_tready,
    output t_sts                   o_sts,
    output logic                   o_tvalid,
    output logic [SYM_W-1:0]       o_tdata,
    output logic                   o_tlast
);

    localparam int CELLS = SIDE * SIDE;
    localparam int IW    = $clog2(CELLS);
    localparam int CW    = $clog2(SIDE);
    localparam int AW    = $clog2(MAX_LEN);
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int JW    = LW + 1;

    localparam logic [IW-1:0]     LAST_CELL = IW'(CELLS - 1);
    localparam logic [IW-1:0]     SIDE_W    = IW'(SIDE);
    localparam logic [CW-1:0]     LAST_COL  = CW'(SIDE - 1);
    localparam logic [LW-1:0]     FULL_LEN  = LW'(MAX_LEN);
    localparam logic [CELL_W:0]   CELL_LIM  = (CELL_W + 1)'(CELLS);

    // keyed square, unloaded cells read as zero through the valid bits
    logic [SYM_W-1:0] r_sq_mem [CELLS];
    logic [CELLS-1:0] r_sq_vld;
    logic [SYM_W-1:0] r_sq_q;
    logic             r_sq_qv;
    logic [IW-1:0]    sq_addr;
    logic [SYM_W-1:0] sq_val;
    logic             cell_ok;

    // scan position and its coordinates
    logic [IW-1:0]    r_scan;
    logic [CW-1:0]    r_srow;
    logic [CW-1:0]    r_scol;
    logic [SYM_W-1:0] r_sym;

    // stored coordinates
    logic [CW-1:0]    r_row_mem [MAX_LEN];
    logic [CW-1:0]    r_col_mem [MAX_LEN];
    logic [CW-1:0]    r_row_q;
    logic [CW-1:0]    r_col_q;
    logic             r_in_row;
    logic [LW-1:0]    r_len;
    logic [JW-1:0]    r_j;
    logic [JW-1:0]    col_off;
    logic [CW-1:0]    coord;
    logic [CW-1:0]    r_first;
    logic [IW-1:0]    pair_idx;

    logic             r_out_vld;
    logic [SYM_W-1:0] r_out_data;
    logic             r_out_last;

    assign cell_ok  = ({1'b0, i_cell} < CELL_LIM);
    assign coord    = r_in_row ? r_row_q : r_col_q;
    assign pair_idx = IW'(r_first) * SIDE_W + IW'(coord);
    assign sq_addr  = i_cmd.sel_pair ? pair_idx : r_scan;
    assign sq_val   = r_sq_qv ? r_sq_q : '0;
    assign col_off  = r_j - JW'(r_len);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_wr && cell_ok) begin
            r_sq_mem[i_cell[IW-1:0]] <= i_symbol;
        end
        if (!i_cmd.sq_hold) begin
            r_sq_q <= r_sq_mem[sq_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= '0;
            r_sq_qv  <= 1'b0;
        end else begin
            if (i_cmd.sq_wr && cell_ok) begin
                r_sq_vld[i_cell[IW-1:0]] <= 1'b1;
            end
            if (!i_cmd.sq_hold) begin
                r_sq_qv <= r_sq_vld[sq_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_sym <= i_symbol;
        end
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
            r_srow <= '0;
            r_scol <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + 1'b1;
            if (r_scol == LAST_COL) begin
                r_scol <= '0;
                r_srow <= r_srow + 1'b1;
            end else begin
                r_scol <= r_scol + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_row_mem[r_len[AW-1:0]] <= r_srow;
            r_col_mem[r_len[AW-1:0]] <= r_scol;
        end
        r_row_q  <= r_row_mem[r_j[AW-1:0]];
        r_col_q  <= r_col_mem[col_off[AW-1:0]];
        r_in_row <= (r_j < JW'(r_len));
        if (i_cmd.latch_r) begin
            r_first <= coord;
        end
        if (i_cmd.seq_clr) begin
            r_j <= '0;
        end else if (i_cmd.coord_inc) begin
            r_j <= r_j + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.len_clr) begin
            r_len <= '0;
        end else if (i_cmd.store) begin
            r_len <= r_len + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= sq_val;
            r_out_last <= o_sts.seq_done;
        end
    end

    assign o_sts.match     = (sq_val == r_sym);
    assign o_sts.scan_last = (r_scan == LAST_CELL);
    assign o_sts.full      = (r_len == FULL_LEN);
    assign o_sts.empty     = (r_len == '0);
    assign o_sts.out_free  = !r_out_vld || i_tready;
    assign o_sts.seq_done  = (r_j == {r_len, 1'b0});

    assign o_tvalid = r_out_vld;
    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/core/bifid_square_encrypt_core.sv -----
// Channel | Dir | tdata (low bit up)                   | tuser   | tlast
// s       | in  | cell_req[5:0], symbol[13:6], 0[15:14] | kind    | -
// m       | out | cipher_symbol[7:0]                    | -       | last
//
// Steps: a load item writes one cell. A message symbol, unless the message is full, scans
// the square one cell at a time through its single read port, a read then a compare per cell.
// A finish item emits its results one at a time, each through two reads of the coordinate
// stores, one square read and one load of the output register.
// Reset: synchronous, active low; clears the square valid bits, the length, the
// controller and the output valid. Coordinate stores are left as they are.
// Stalls: a held result freezes the emission walk; the next item is taken while
// the final result of a message still waits in the output register.
`default_nettype none

module bifid_square_encrypt_core
    import bse_pkg::*;
#(
    parameter int SIDE    = DEF_SIDE,
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [15:0]       i_s_tdata,   // cell_req[5:0], symbol[13:6]
    input  wire logic [KIND_W-1:0] i_s_tuser,   // kind[1:0]
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [SYM_W-1:0]       o_m_tdata,   // cipher_symbol[7:0]
    output logic                   o_m_tlast
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: load, scan and emission steps
    bse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .i_kind   (i_s_tuser),
        .i_sts    (sts),
        .o_tready (o_s_tready),
        .o_cmd    (cmd)
    );

    // square, coordinate stores, counters and output register
    bse_dp #(
        .SIDE    (SIDE),
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_cell   (i_s_tdata[CELL_W-1:0]),
        .i_symbol (i_s_tdata[CELL_W+SYM_W-1:CELL_W]),
        .i_tready (i_m_tready),
        .o_sts    (sts),
        .o_tvalid (o_m_tvalid),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/core/bse_chk.sv -----
`default_nettype none

module bse_chk
    import bse_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_tvalid,
    input wire logic              o_s_tready,
    input wire logic [15:0]       i_s_tdata,
    input wire logic [KIND_W-1:0] i_s_tuser,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [SYM_W-1:0]  o_m_tdata,
    input wire logic              o_m_tlast
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // no new item while a message is still being emitted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input taken during emission");

    // a load item leaves the block ready
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == KIND_LOAD) |=> o_s_tready)
        else $error("load item stalled the input");

endmodule

bind bifid_square_encrypt_core bse_chk u_chk (.*);

`default_nettype wire

// ----- sim/bifid_square_encrypt_core_tb.sv -----
`default_nettype none

module bifid_square_encrypt_core_tb;
    import bse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE    = DEF_SIDE;
    localparam int MAX_LEN = DEF_MAX_LEN;
    localparam int CELLS   = SIDE * SIDE;

    // kind code the block has no use for; such items must vanish
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    localparam int ITEM_TARGET = 380;
    localparam int SETTLE_CYC  = 400;

    // one ciphertext symbol as it leaves the block
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } cipher_t;

    // one row of the directed table; typed rows carry their own answer
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CELL_W-1:0] cell_req;
        logic [SYM_W-1:0]  sym;
        bit                typed;
        bit                n_exp;
        logic [SYM_W-1:0]  exp_sym;
        logic              exp_last;
    } stim_row_t;

    logic              i_clk;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [15:0]       i_s_tdata  = '0;   // cell_req[5:0], symbol[13:6], 0[15:14]
    logic [KIND_W-1:0] i_s_tuser  = '0;   // kind[1:0]
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [SYM_W-1:0]  o_m_tdata;         // cipher_symbol[7:0]
    logic              o_m_tlast;

    bifid_square_encrypt_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Predictor state: keyed square, stored coordinates and message length
    logic [SYM_W-1:0] key_sq    [CELLS];
    logic [2:0]       row_coord [MAX_LEN];
    logic [2:0]       col_coord [MAX_LEN];
    int               msg_len;

    cipher_t cipher_expect [$];

    int errors      = 0;
    int items_sent  = 0;
    int send_idle   = 16;   // percent of cycles the sender holds back
    int recv_idle   = 64;   // percent of cycles the receiver stalls

    // Directed part. After reset the square is all zeros, so symbol zero
    // hits cell 0 and anything else misses.
    stim_row_t dir_tab [0:17] = '{
        '{KIND_MSG,  6'd0,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},  // lowest zero cell
        '{KIND_MSG,  6'd0,  8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},  // symbol not found
        '{KIND_FIN,  6'd0,  8'h00, 1'b1, 1'b1, 8'h00, 1'b1},  // pair (0,0)
        '{KIND_FIN,  6'd0,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},  // empty finish
        '{KIND_NONE, 6'd63, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},  // unused kind
        '{KIND_LOAD, 6'd63, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b0},  // load out of range
        '{KIND_LOAD, 6'd35, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
        '{KIND_LOAD, 6'd0,  8'h01, 1'b1, 1'b0, 8'h00, 1'b0},
        '{KIND_MSG,  6'd0,  8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
        '{KIND_MSG,  6'd0,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},  // duplicate codes
        '{KIND_MSG,  6'd0,  8'h01, 1'b1, 1'b0, 8'h00, 1'b0},
        '{KIND_FIN,  6'd0,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},  // odd length
        '{KIND_MSG,  6'd0,  8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
        '{KIND_FIN,  6'd0,  8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},  // pair (5,5)
        '{KIND_MSG,  6'd0,  8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
        '{KIND_LOAD, 6'd36, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},  // first cell past end
        '{KIND_FIN,  6'd0,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{KIND_NONE, 6'd0,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0}
    };

    // Append one symbol to the tail of the expectation queue
    function automatic void queue_expect(input cipher_t res);
        cipher_expect = {cipher_expect, res};
    endfunction

    // Coordinate k of the rows-then-columns sequence
    function automatic logic [2:0] coord_at(input int k);
        if (k < msg_len)
            return row_coord[k];
        return col_coord[k - msg_len];
    endfunction

    // Advance the predictor by one item; queue the ciphertext it causes
    function automatic void bifid_encrypt_step(input logic [KIND_W-1:0] kind,
                                               input logic [CELL_W-1:0] cell_req,
                                               input logic [SYM_W-1:0]  sym,
                                               input bit                push);
        int      idx;
        bit      found;
        cipher_t res;
        case (kind)
            KIND_LOAD: begin
                if (int'(cell_req) < CELLS)
                    key_sq[cell_req] = sym;
            end
            KIND_MSG: begin
                found = 1'b0;
                if (msg_len < MAX_LEN) begin
                    for (idx = 0; idx < CELLS && !found; idx++) begin
                        if (key_sq[idx] == sym) begin
                            row_coord[msg_len] = 3'(idx / SIDE);
                            col_coord[msg_len] = 3'(idx % SIDE);
                            found = 1'b1;
                        end
                    end
                    if (found)
                        msg_len++;
                end
            end
            KIND_FIN: begin
                for (int k = 0; k < msg_len; k++) begin
                    idx      = int'(coord_at(2 * k)) * SIDE + int'(coord_at(2 * k + 1));
                    res.sym  = (idx < CELLS) ? key_sq[idx] : '0;
                    res.last = (k + 1 == msg_len);
                    if (push)
                        queue_expect(res);
                end
                msg_len = 0;
            end
            default: begin
            end
        endcase
    endfunction

    // Offer one item from a falling edge; hold it until the block takes it
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [CELL_W-1:0] cell_req,
                             input logic [SYM_W-1:0]  sym,
                             input bit                push);
        while ($urandom_range(0, 99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {2'b00, sym, cell_req};
        do @(posedge i_clk); while (!o_s_tready);
        bifid_encrypt_step(kind, cell_req, sym, push);
        // ignored items do not count toward the run length
        if (!(kind == KIND_NONE || (kind == KIND_LOAD && int'(cell_req) >= CELLS)))
            items_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every queued symbol has come out
    task automatic drain_cipher;
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (cipher_expect.size() != 0)
            @(negedge i_clk);
    endtask

    // Fill the square with distinct codes; sometimes plant one duplicate
    task automatic load_square;
        bit         used [256];
        logic [7:0] code;
        foreach (used[i])
            used[i] = 1'b0;
        for (int c = 0; c < CELLS; c++) begin
            do code = 8'($urandom); while (used[code]);
            used[code] = 1'b1;
            send_item(KIND_LOAD, 6'(c), code, 1'b1);
        end
        if ($urandom_range(0, 4) == 0)
            send_item(KIND_LOAD, 6'($urandom_range(0, CELLS - 1)),
                      key_sq[$urandom_range(0, CELLS - 1)], 1'b1);
    endtask

    // One item of noise: ignored kinds, stray loads, misses, early finishes
    task automatic send_noise;
        case ($urandom_range(0, 4))
            0: send_item(KIND_NONE, 6'($urandom), 8'($urandom), 1'b1);
            1: send_item(KIND_LOAD, 6'($urandom_range(CELLS, 63)), 8'($urandom), 1'b1);
            2: send_item(KIND_LOAD, 6'($urandom_range(0, CELLS - 1)), 8'($urandom), 1'b1);
            3: send_item(KIND_MSG, 6'($urandom), 8'($urandom), 1'b1);
            default: send_item(KIND_FIN, 6'($urandom), 8'($urandom), 1'b1);
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: decide ready at each falling edge
    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle);

    // Compare every accepted symbol with the oldest expectation
    always @(posedge i_clk) begin
        cipher_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (cipher_expect.size() == 0) begin
                errors++;
                $display("%0t: unexpected symbol %02h last %0b", $time, o_m_tdata, o_m_tlast);
            end else begin
                want = cipher_expect.pop_front();
                if (o_m_tdata !== want.sym) begin
                    errors++;
                    $display("%0t: cipher_symbol expected %02h actual %02h",
                             $time, want.sym, o_m_tdata);
                end
                if (o_m_tlast !== want.last) begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b", $time, want.last, o_m_tlast);
                end
            end
        end
    end

    initial begin
        int      msg_syms;
        bit      first_round;
        cipher_t typed_res;

        foreach (key_sq[i])
            key_sq[i] = '0;
        msg_len     = 0;
        first_round = 1'b1;

        // hold reset, then release it on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table: typed rows queue their own answer
        foreach (dir_tab[r]) begin
            send_item(dir_tab[r].kind, dir_tab[r].cell_req, dir_tab[r].sym,
                      !dir_tab[r].typed);
            if (dir_tab[r].typed && dir_tab[r].n_exp) begin
                typed_res.sym  = dir_tab[r].exp_sym;
                typed_res.last = dir_tab[r].exp_last;
                queue_expect(typed_res);
            end
        end
        drain_cipher();
        items_sent = 0;

        // random rounds: key the square, send a message, finish it
        while (items_sent < ITEM_TARGET) begin
            if (items_sent < ITEM_TARGET / 3) begin
                send_idle = 16;
                recv_idle = 64;
            end else if (items_sent < 2 * ITEM_TARGET / 3) begin
                send_idle = 64;
                recv_idle = 16;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end

            if (first_round || $urandom_range(0, 2) == 0)
                load_square();

            // mostly short messages; now and then one near or past capacity
            if (first_round || $urandom_range(0, 7) == 0)
                msg_syms = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
            else
                msg_syms = $urandom_range(1, 12);

            for (int s = 0; s < msg_syms; s++) begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                if ($urandom_range(0, 7) == 0)
                    send_item(KIND_MSG, 6'($urandom), 8'($urandom), 1'b1);
                else
                    send_item(KIND_MSG, 6'($urandom),
                              key_sq[$urandom_range(0, CELLS - 1)], 1'b1);
            end

            // now and then carry the message over into the next round
            if ($urandom_range(0, 11) != 0)
                send_item(KIND_FIN, 6'($urandom), 8'($urandom), 1'b1);
            if ($urandom_range(0, 3) == 0)
                drain_cipher();
            first_round = 1'b0;
        end
        send_item(KIND_FIN, 6'($urandom), 8'($urandom), 1'b1);

        i_s_tvalid <= 1'b0;
        while (cipher_expect.size() != 0)
            @(posedge i_clk);
        // allow the emission walk to finish; any stray symbol is flagged
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (errors == 0 && cipher_expect.size() == 0)
            $display("** bifid_square_encrypt_core: PASSED **");
        else
            $display("** bifid_square_encrypt_core: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("** bifid_square_encrypt_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
